/* hw/rtl/dqr_pkg.sv */
// shared types and codes for the deque with remove-by-value
// no dependencies; every other file refers to this package by scoped names
package dqr_pkg;

	localparam int CNT_W = 5;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_REMOVE     = 3'd4;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_REMOVE,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FULL,
		ST_NOTFOUND
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_WAIT,
		S_SEARCH,
		S_SHIFT
	} state_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		status_t            status;
		logic [CNT_W-1:0]   entry_count;
	} result_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} work_t;

endpackage

/* hw/rtl/dqr_front.sv */
// front end: accepts items and classifies the command into an operation
// depends on dqr_pkg
module dqr_front (
	input  logic           start,
	input  dqr_pkg::item_t item,
	input  logic           q_full,
	output logic           busy,
	output logic           q_push,
	output dqr_pkg::work_t work
);

	assign busy   = q_full;
	assign q_push = start & ~q_full;

	always_comb begin
		work.value = item.value;
		unique case (item.cmd)
			dqr_pkg::CMD_PUSH_FRONT: work.op = dqr_pkg::OP_PUSH_FRONT;
			dqr_pkg::CMD_PUSH_BACK:  work.op = dqr_pkg::OP_PUSH_BACK;
			dqr_pkg::CMD_POP_FRONT:  work.op = dqr_pkg::OP_POP_FRONT;
			dqr_pkg::CMD_POP_BACK:   work.op = dqr_pkg::OP_POP_BACK;
			dqr_pkg::CMD_REMOVE:     work.op = dqr_pkg::OP_REMOVE;
			default:                 work.op = dqr_pkg::OP_NOP;
		endcase
	end

endmodule

/* hw/rtl/dqr_queue.sv */
// two-entry queue of classified items between front and back
// depends on dqr_pkg
module dqr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dqr_pkg::work_t wr_data,
	input  logic           pop,
	output logic           q_valid,
	output logic           q_full,
	output dqr_pkg::work_t head
);

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	dqr_pkg::work_t  ent_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  cnt_q;

	assign q_valid = (cnt_q != '0);
	assign q_full  = (cnt_q == QCW'(QDEPTH));
	assign head    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* hw/rtl/dqr_back.sv */
// back end: ring-buffer store, pointer and count, sequencer for pops and remove-by-value
// depends on dqr_pkg; takes work from dqr_queue and drives the result strobe
module dqr_back #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  dqr_pkg::work_t   head,
	output logic             q_pop,
	output logic             done,
	output dqr_pkg::result_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_data_q;

	dqr_pkg::state_t    state_q, state_d;
	dqr_pkg::op_t       op_q;
	logic signed [31:0] val_q;
	logic signed [31:0] taken_q, taken_d;
	logic [AW-1:0]      front_q, front_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      idx_q, idx_d;

	logic               done_q, done_d;
	dqr_pkg::result_t   res_q;
	logic signed [31:0] res_val_d;
	dqr_pkg::status_t   res_st_d;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;

	logic               empty, full, hit, more, more2;
	logic [CW-1:0]      idx1, idx2;
	logic [AW-1:0]      front_m1, front_p1;

	function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
			input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(pos);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [dqr_pkg::CNT_W-1:0] to_cnt(input logic [CW-1:0] c);
		logic [CW+dqr_pkg::CNT_W-1:0] w;
		w = (CW + dqr_pkg::CNT_W)'(c);
		return w[dqr_pkg::CNT_W-1:0];
	endfunction

	assign empty    = (count_q == '0);
	assign full     = (count_q >= CW'(DEPTH));
	assign hit      = (rd_data_q == val_q);
	assign idx1     = idx_q + 1'b1;
	assign idx2     = idx_q + CW'(2);
	assign more     = (idx1 < count_q);
	assign more2    = (idx2 < count_q);
	assign front_m1 = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_p1 = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;

	assign done   = done_q;
	assign result = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dqr_pkg::S_IDLE: begin
				if (q_valid && !empty) begin
					if (head.op == dqr_pkg::OP_POP_FRONT ||
							head.op == dqr_pkg::OP_POP_BACK) begin
						state_d = dqr_pkg::S_POP_WAIT;
					end else if (head.op == dqr_pkg::OP_REMOVE) begin
						state_d = dqr_pkg::S_SEARCH;
					end
				end
			end
			dqr_pkg::S_POP_WAIT: state_d = dqr_pkg::S_IDLE;
			dqr_pkg::S_SEARCH: begin
				if (hit) begin
					state_d = more ? dqr_pkg::S_SHIFT : dqr_pkg::S_IDLE;
				end else if (!more) begin
					state_d = dqr_pkg::S_IDLE;
				end
			end
			dqr_pkg::S_SHIFT: begin
				if (!more2) begin
					state_d = dqr_pkg::S_IDLE;
				end
			end
			default: state_d = dqr_pkg::S_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = front_q;
		mem_wdata = head.value;
		mem_raddr = front_q;
		front_d   = front_q;
		count_d   = count_q;
		idx_d     = idx_q;
		taken_d   = taken_q;
		done_d    = 1'b0;
		res_val_d = '0;
		res_st_d  = dqr_pkg::ST_OK;
		unique case (state_q)
			dqr_pkg::S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (head.op) inside
						dqr_pkg::OP_PUSH_FRONT: begin
							done_d = 1'b1;
							if (full) begin
								res_st_d = dqr_pkg::ST_FULL;
							end else begin
								front_d   = front_m1;
								mem_we    = 1'b1;
								mem_waddr = front_m1;
								count_d   = count_q + 1'b1;
							end
						end
						dqr_pkg::OP_PUSH_BACK: begin
							done_d = 1'b1;
							if (full) begin
								res_st_d = dqr_pkg::ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = wrap_slot(front_q, count_q);
								count_d   = count_q + 1'b1;
							end
						end
						dqr_pkg::OP_POP_FRONT, dqr_pkg::OP_REMOVE: begin
							idx_d = '0;
							if (empty) begin
								done_d   = 1'b1;
								res_st_d = dqr_pkg::ST_EMPTY;
							end
						end
						dqr_pkg::OP_POP_BACK: begin
							if (empty) begin
								done_d   = 1'b1;
								res_st_d = dqr_pkg::ST_EMPTY;
							end else begin
								mem_raddr = wrap_slot(front_q, count_q - 1'b1);
							end
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			dqr_pkg::S_POP_WAIT: begin
				done_d    = 1'b1;
				res_val_d = rd_data_q;
				count_d   = count_q - 1'b1;
				if (op_q == dqr_pkg::OP_POP_FRONT) begin
					front_d = front_p1;
				end
			end
			dqr_pkg::S_SEARCH: begin
				// rd_data_q holds the entry at position idx_q from the front
				if (hit) begin
					taken_d = rd_data_q;
					if (more) begin
						mem_raddr = wrap_slot(front_q, idx1);
					end else begin
						done_d    = 1'b1;
						res_val_d = rd_data_q;
						count_d   = count_q - 1'b1;
					end
				end else if (more) begin
					mem_raddr = wrap_slot(front_q, idx1);
					idx_d     = idx1;
				end else begin
					done_d   = 1'b1;
					res_st_d = dqr_pkg::ST_NOTFOUND;
				end
			end
			dqr_pkg::S_SHIFT: begin
				// rd_data_q holds entry idx_q+1, moved down into idx_q
				mem_we    = 1'b1;
				mem_waddr = wrap_slot(front_q, idx_q);
				mem_wdata = rd_data_q;
				if (more2) begin
					mem_raddr = wrap_slot(front_q, idx2);
					idx_d     = idx1;
				end else begin
					done_d    = 1'b1;
					res_val_d = taken_q;
					count_d   = count_q - 1'b1;
				end
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqr_pkg::S_IDLE;
			front_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q  <= head.op;
			val_q <= head.value;
		end
		idx_q              <= idx_d;
		taken_q            <= taken_d;
		res_q.result_value <= res_val_d;
		res_q.status       <= res_st_d;
		res_q.entry_count  <= to_cnt(count_d);
	end

	// entry store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_done_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == dqr_pkg::S_IDLE)
		else $error("result given while sequencer still busy");

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dqr_pkg::S_SEARCH |-> idx_q < count_q)
		else $error("search position beyond held entries");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dqr_pkg::S_SHIFT |-> idx1 < count_q)
		else $error("shift source beyond held entries");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");
`endif

endmodule

/* hw/rtl/deque_with_remove_by_value_core.sv */
// top level of the bounded deque with remove-by-value
// depends on dqr_pkg, dqr_front, dqr_queue, dqr_back
//
//   channel | ports                  | handshake
//   --------+------------------------+------------------------------------
//   request | item (cmd, value)      | taken when start && !busy
//   result  | result (value, status, | done high for one cycle per item,
//           |   entry_count)         |   no back pressure
//
// after reset the store is empty; no clearing pass is needed
// a taken request is written into the request queue before the back end sees it,
// and its result is strobed in the cycle after the back end finishes it
// push, ignored command or error end in idle; a pop ends in a wait state;
// a remove searches and shifts entries through the single read port of the store
// busy rises only while the two-entry request queue is full

module deque_with_remove_by_value_core #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  dqr_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output dqr_pkg::result_t result
);

	logic           q_push;
	logic           q_pop;
	logic           q_valid;
	logic           q_full;
	dqr_pkg::work_t work;
	dqr_pkg::work_t head;

	dqr_front u_front (
		.start  (start),
		.item   (item),
		.q_full (q_full),
		.busy   (busy),
		.q_push (q_push),
		.work   (work)
	);

	dqr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (work),
		.pop     (q_pop),
		.q_valid (q_valid),
		.q_full  (q_full),
		.head    (head)
	);

	dqr_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.q_pop   (q_pop),
		.done    (done),
		.result  (result)
	);

endmodule
